// ===== src/legendre_value_evaluator_unit_assert.svh =====
// assertion macros for the legendre value evaluator
`ifndef LEGENDRE_VALUE_EVALUATOR_UNIT_ASSERT_SVH
`define LEGENDRE_VALUE_EVALUATOR_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LVE_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the cycle after the antecedent
`define LVE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/lve_pkg.sv =====
// package for the legendre value evaluator: sizes and sequencer states
`default_nettype none
package lve_pkg;
    localparam int unsigned DEF_MAX_DEGREE = 255;
    localparam int unsigned DEF_FRAC_BITS  = 30;
    localparam int unsigned IN_W  = 32;
    localparam int unsigned DEG_W = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_COMMIT,
        ST_STEP_END,
        ST_OUT
    } lve_state_t;
endpackage
`default_nettype wire

// ===== src/legendre_value_evaluator_unit.sv =====
// top level: legendre polynomial evaluator with a shared shift-add multiplier and divider
//
// Evaluates P_n(x) with the Bonnet recurrence, one recurrence step at a time. Each step
// runs a setup state, a bit-serial multiply of (2i+1)|x| by |P_i| (one bit per cycle
// over the VW = FRAC_BITS+1 bit magnitude), a rounding state, a restoring division by
// (i+1) one quotient bit per cycle over QW bits, and a commit state. An item of degree n
// (capped at MAX_DEGREE) runs n-1 such steps, none for degree 0. Input is not ready until
// the result beat has been taken. No state is kept between items.
`default_nettype none
`include "legendre_value_evaluator_unit_assert.svh"
module legendre_value_evaluator_unit #(
    parameter int unsigned MAX_DEGREE = lve_pkg::DEF_MAX_DEGREE,
    parameter int unsigned FRAC_BITS  = lve_pkg::DEF_FRAC_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [lve_pkg::DEG_W-1:0] degree,
    input  wire logic signed [lve_pkg::IN_W-1:0] x_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [lve_pkg::IN_W-1:0] poly_value,
    output logic                         saturated
);
    import lve_pkg::*;

    // sizes: step index, magnitudes, products
    localparam int unsigned IW  = $clog2(MAX_DEGREE + 2);
    localparam int unsigned VW  = FRAC_BITS + 1;          // magnitude of a value <= one
    localparam int unsigned MW  = VW + IW + 1;            // (2i+1)*|x|
    localparam int unsigned PW  = MW + VW + 1;            // numerator magnitude
    localparam int unsigned QW  = PW - FRAC_BITS;         // shifted numerator width
    localparam int unsigned CW  = $clog2(PW + 1);
    localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;
    localparam logic signed [IN_W-1:0] ONE_Q = IN_W'(ONE);

    lve_state_t state_reg, state_next;

    logic [IW-1:0]  i_reg, n_reg;
    logic [VW-1:0]  xm_reg, cur_reg, prev_reg;
    logic           xn_reg, curn_reg, prevn_reg, sat_reg;
    logic [PW-1:0]  mcand_reg;                // shifted multiplicand (2i+1)|x|
    logic [VW-1:0]  mplier_reg;               // remaining multiplier bits
    logic [PW:0]    acc_reg;                  // two's complement numerator, relative to sign of b
    logic [QW-1:0]  dvd_reg;                  // dividend bits still to bring down
    logic [QW-1:0]  rem_reg, quo_reg;
    logic [CW-1:0]  cnt_reg;
    logic           neg_reg;
    logic signed [IN_W-1:0] res_reg;
    logic           ressat_reg;

    // input decode with argument clamp
    logic signed [IN_W:0] xin;
    logic [VW-1:0] xin_mag;
    logic xin_neg, xin_sat;
    logic [IW-1:0] deg_sat;
    always_comb
    begin
        xin = {x_value[IN_W-1], x_value};
        xin_sat = 1'b0;
        if (xin > $signed({1'b0, {(IN_W-VW){1'b0}}, ONE}))
        begin
            xin = $signed({1'b0, {(IN_W-VW){1'b0}}, ONE});
            xin_sat = 1'b1;
        end
        else if (xin < -$signed({1'b0, {(IN_W-VW){1'b0}}, ONE}))
        begin
            xin = -$signed({1'b0, {(IN_W-VW){1'b0}}, ONE});
            xin_sat = 1'b1;
        end
        xin_neg = xin[IN_W];
        xin_mag = xin_neg ? VW'(-xin) : VW'(xin);
        deg_sat = (32'(degree) > MAX_DEGREE) ? IW'(MAX_DEGREE) : IW'(degree);
    end

    // step setup: small products for multiplicand and the i*|prev| term
    logic [MW-1:0]    mc_prod;
    logic [IW+VW-1:0] b_prod;
    logic             step_more;
    always_comb
    begin
        mc_prod   = {i_reg, 1'b1} * xm_reg;
        b_prod    = i_reg * prev_reg;
        step_more = (i_reg < n_reg);
    end

    // shared accumulate: acc starts at |b| and adds or subtracts |a| by sign
    logic          mul_sub;
    logic [PW:0]   addend, acc_sum;
    always_comb
    begin
        mul_sub = xn_reg ^ curn_reg ^ ~prevn_reg;
        addend  = mul_sub ? ~{1'b0, mcand_reg} : {1'b0, mcand_reg};
        acc_sum = acc_reg + addend + (PW+1)'(mul_sub);
    end

    // magnitude plus half the divisor, ties away from zero
    logic [PW:0] half_rnd, mag_rnd;
    always_comb
    begin
        half_rnd = ((PW+1)'(i_reg) + (PW+1)'(1)) << (FRAC_BITS - 1);
        mag_rnd  = half_rnd + (acc_reg[PW] ? ~acc_reg : acc_reg) + (PW+1)'(acc_reg[PW]);
    end

    // restoring divider step
    logic [QW:0]   rem_shift;
    logic [QW:0]   dsub;
    logic [QW-1:0] divisor;
    always_comb
    begin
        divisor   = QW'(i_reg) + QW'(1);
        rem_shift = {rem_reg, dvd_reg[QW-1]};
        dsub      = rem_shift - {1'b0, divisor};
    end

    // quotient clamp to one
    logic [VW-1:0] q_clamp;
    logic          q_over;
    always_comb
    begin
        q_over  = quo_reg > QW'(ONE);
        q_clamp = q_over ? ONE : VW'(quo_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_STEP_END;
            ST_STEP_END: state_next = step_more ? ST_MUL : ST_OUT;
            ST_MUL:      if (cnt_reg == CW'(1)) state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:      if (cnt_reg == CW'(1)) state_next = ST_COMMIT;
            ST_COMMIT:   state_next = ST_STEP_END;
            ST_OUT:      if (out_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        out_valid  = (state_reg == ST_OUT);
        poly_value = res_reg;
        saturated  = ressat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                n_reg     <= deg_sat;
                i_reg     <= IW'(1);
                xm_reg    <= xin_mag;
                xn_reg    <= xin_neg;
                sat_reg   <= xin_sat;
                prev_reg  <= ONE;
                prevn_reg <= 1'b0;
                // degree zero carries one as the final value
                cur_reg   <= (deg_sat == '0) ? ONE : xin_mag;
                curn_reg  <= (deg_sat == '0) ? 1'b0 : xin_neg;
            end
            ST_STEP_END:
            begin
                mcand_reg  <= PW'(mc_prod);
                mplier_reg <= cur_reg;
                acc_reg    <= (PW+1)'(b_prod) << FRAC_BITS;
                cnt_reg    <= CW'(VW);
                if (!step_more)
                begin
                    res_reg    <= curn_reg ? -IN_W'(cur_reg) : IN_W'(cur_reg);
                    ressat_reg <= sat_reg;
                end
            end
            ST_MUL:
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_sum;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg - CW'(1);
            end
            ST_DIV_INIT:
            begin
                neg_reg <= ~prevn_reg ^ acc_reg[PW];
                dvd_reg <= QW'(mag_rnd >> FRAC_BITS);
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= CW'(QW);
            end
            ST_DIV:
            begin
                if (!dsub[QW])
                begin
                    rem_reg <= dsub[QW-1:0];
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift[QW-1:0];
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg - CW'(1);
            end
            ST_COMMIT:
            begin
                prev_reg  <= cur_reg;
                prevn_reg <= curn_reg;
                cur_reg   <= q_clamp;
                curn_reg  <= neg_reg & (q_clamp != '0);
                sat_reg   <= sat_reg | q_over;
                i_reg     <= i_reg + IW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // checks
    `LVE_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, !out_valid, "ready while result held")
    `LVE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(poly_value) && $stable(saturated), "result beat changed")
    `LVE_ASSERT_IMP(a_range, clk, rst_n, out_valid,
        poly_value <= ONE_Q && poly_value >= -ONE_Q, "result out of range")
endmodule
`default_nettype wire
